// File: src/urlpd_pkg.sv
// shared types, character constants and hex helpers for the url percent decoder
// no dependencies
`default_nettype none

package urlpd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned LEN_W = 16;
  localparam int unsigned MAX_RES = 3;

  // escape phase, one-hot
  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_PCT   = 3'b010,
    PH_HEX1  = 3'b100
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // one decoded request worth of results
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              n_res;     // results held, 1 to 3
    logic                    has_data;  // 0 only for the empty final result
    logic                    last;
    logic                    trunc;
  } urlpd_pkt_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h41 + 8'd10);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: src/urlpd_decode.sv
// escape state machine, output limit check and the decoded packet register
// depends on urlpd_pkg
`default_nettype none

module urlpd_decode (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         in_last_i,
  input  wire logic [urlpd_pkg::LEN_W-1:0]  max_len_i,
  output      logic                         pkt_valid_o,
  input  wire logic                         pkt_take_i,
  output      urlpd_pkg::urlpd_pkt_t        pkt_o
);
  import urlpd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [7:0]       hold_q, hold_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             a_valid_q, a_valid_d;
  urlpd_pkt_t       pkt_q, pkt_d;

  logic [3:0][7:0]  raw;
  logic [1:0]       nraw;
  phase_e           ph_n;
  logic [7:0]       hold_n;
  logic             do_plain;
  hex_t             hx_in, hx_hold;
  logic [LEN_W:0]   cnt_x;
  logic [2:0]       room;
  logic [1:0]       kept;
  logic             dropped;
  logic             accept;
  logic             load;

  assign hx_in   = hex_digit(in_byte_i);
  assign hx_hold = hex_digit(hold_q);

  // raw decoded bytes for this request
  always_comb begin
    raw      = '0;
    nraw     = 2'd0;
    ph_n     = PH_PLAIN;
    hold_n   = hold_q;
    do_plain = 1'b0;
    case (phase_q)
      PH_PCT: begin
        if (hx_in.ok) begin
          hold_n = in_byte_i;
          ph_n   = PH_HEX1;
        end else begin
          raw[0]   = CH_PERCENT;
          nraw     = 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_HEX1: begin
        if (hx_in.ok) begin
          raw[0] = {hx_hold.val, hx_in.val};
          nraw   = 2'd1;
        end else begin
          raw[0]   = CH_PERCENT;
          raw[1]   = hold_q;
          nraw     = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    if (do_plain) begin
      if (in_byte_i == CH_PERCENT) begin
        ph_n = PH_PCT;
      end else begin
        raw[nraw] = (in_byte_i == CH_PLUS) ? CH_SPACE : in_byte_i;
        nraw      = nraw + 2'd1;
      end
    end

    // flush a pending escape at end of string
    if (in_last_i) begin
      if (ph_n == PH_PCT) begin
        raw[nraw] = CH_PERCENT;
        nraw      = nraw + 2'd1;
      end else if (ph_n == PH_HEX1) begin
        raw[nraw]        = CH_PERCENT;
        raw[nraw + 2'd1] = hold_n;
        nraw             = nraw + 2'd2;
      end
    end
  end

  // limit check, room for each of the three slots
  assign cnt_x   = {1'b0, cnt_q};
  assign room[0] = cnt_x          < {1'b0, max_len_i};
  assign room[1] = (cnt_x + 17'd1) < {1'b0, max_len_i};
  assign room[2] = (cnt_x + 17'd2) < {1'b0, max_len_i};
  assign kept    = 2'({1'b0, (nraw > 2'd0) & room[0]})
                 + 2'({1'b0, (nraw > 2'd1) & room[1]})
                 + 2'({1'b0, (nraw > 2'd2) & room[2]});
  assign dropped = (kept != nraw);

  assign in_ready_o = !a_valid_q || pkt_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && ((kept != 2'd0) || in_last_i);

  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    if (accept) begin
      if (in_last_i) begin
        phase_d = PH_PLAIN;
        hold_d  = 8'd0;
        cnt_d   = '0;
        drop_d  = 1'b0;
      end else begin
        phase_d = ph_n;
        hold_d  = hold_n;
        cnt_d   = cnt_q + LEN_W'(kept);
        drop_d  = drop_q | dropped;
      end
    end
  end

  always_comb begin
    pkt_d          = pkt_q;
    pkt_d.bytes    = raw[MAX_RES-1:0];
    pkt_d.n_res    = (kept == 2'd0) ? 2'd1 : kept;
    pkt_d.has_data = (kept != 2'd0);
    pkt_d.last     = in_last_i;
    pkt_d.trunc    = in_last_i & (drop_q | dropped);
  end

  assign a_valid_d = (a_valid_q && !pkt_take_i) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PLAIN;
      hold_q    <= 8'd0;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hold_q    <= hold_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_valid_o = a_valid_q;
  assign pkt_o       = pkt_q;

endmodule

`default_nettype wire

// File: src/urlpd_unroll.sv
// output stage: holds one decoded packet and hands its results out one a cycle while out_ready_i is high
// depends on urlpd_pkg
`default_nettype none

module urlpd_unroll (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pkt_valid_i,
  output      logic                  pkt_take_o,
  input  wire urlpd_pkg::urlpd_pkt_t pkt_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            out_byte_o,
  output      logic                  has_data_o,
  output      logic                  out_last_o,
  output      logic                  was_truncated_o
);
  import urlpd_pkg::*;

  logic       b_valid_q, b_valid_d;
  logic [1:0] idx_q, idx_d;
  urlpd_pkt_t b_pkt_q;
  logic       at_end;
  logic       fire;

  assign at_end     = (idx_q == (b_pkt_q.n_res - 2'd1));
  assign fire       = b_valid_q && out_ready_i;
  assign pkt_take_o = pkt_valid_i && (!b_valid_q || (fire && at_end));

  always_comb begin
    b_valid_d = b_valid_q;
    idx_d     = idx_q;
    if (fire) begin
      idx_d = idx_q + 2'd1;
      if (at_end) begin
        b_valid_d = 1'b0;
      end
    end
    if (pkt_take_o) begin
      b_valid_d = 1'b1;
      idx_d     = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      b_valid_q <= b_valid_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_take_o) begin
      b_pkt_q <= pkt_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = b_pkt_q.bytes[0];
      2'd1:    out_byte_o = b_pkt_q.bytes[1];
      default: out_byte_o = b_pkt_q.bytes[2];
    endcase
    if (!b_pkt_q.has_data) begin
      out_byte_o = 8'd0;
    end
  end

  assign out_valid_o     = b_valid_q;
  assign has_data_o      = b_pkt_q.has_data;
  assign out_last_o      = b_pkt_q.last & at_end;
  assign was_truncated_o = b_pkt_q.trunc & at_end;

endmodule

`default_nettype wire

// File: src/url_percent_decoder.sv
// top level of the form-urlencoded percent decoder
// depends on urlpd_pkg, urlpd_decode and urlpd_unroll
`default_nettype none

// Decodes an application/x-www-form-urlencoded string that arrives one byte per
// request, with in_last_i on the final byte. '+' becomes a space and '%' with two
// hex digits becomes the byte they spell; a broken escape is passed through as is
// and a pending '%' or '%h' is flushed at end of string. At most max_out_len bytes
// are produced per string (written through the cfg channel, reset value 499); later
// bytes are dropped and was_truncated_o is raised on the final result. If nothing
// of the final request survives, one result with has_data_o low carries the end
// mark. Timing: the decode and limit check are done in the cycle a request is taken;
// its packet is registered in the decode packet register and then in the output
// packet register. One request is taken per cycle as long as each yields at most
// one result and out_ready_i is high; a request that yields k results (k up to 3,
// from a broken escape) holds the single output port until all k have left, and
// the two packet registers between decoder and output absorb such short bursts.
module url_percent_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input stream
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         in_last_i,
  // result stream
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [7:0]                   out_byte_o,
  output      logic                         has_data_o,
  output      logic                         out_last_o,
  output      logic                         was_truncated_o,
  // max_out_len register write
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [urlpd_pkg::LEN_W-1:0]  cfg_max_out_len_i
);
  import urlpd_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd499;

  logic [LEN_W-1:0] max_len_q, max_len_d;
  logic             pkt_valid;
  logic             pkt_take;
  urlpd_pkt_t       pkt;

  // config register, always writable
  assign cfg_ready_o = 1'b1;
  assign max_len_d   = (cfg_valid_i && cfg_ready_o) ? cfg_max_out_len_i : max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // escape decode, limit check, first packet register
  urlpd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .max_len_i   (max_len_q),
    .pkt_valid_o (pkt_valid),
    .pkt_take_i  (pkt_take),
    .pkt_o       (pkt)
  );

  // output packet register, one result per cycle while out_ready_i is high
  urlpd_unroll u_unroll (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pkt_valid_i     (pkt_valid),
    .pkt_take_o      (pkt_take),
    .pkt_i           (pkt),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .has_data_o      (has_data_o),
    .out_last_o      (out_last_o),
    .was_truncated_o (was_truncated_o)
  );

  // an empty result only ever closes a string
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> out_last_o)
    else $error("empty result without end mark");

  // an empty final result means something of the string was dropped
  a_empty_means_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> was_truncated_o)
    else $error("empty result without truncation");

  // truncation is flagged on the final result only
  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_truncated_o) |-> out_last_o)
    else $error("truncation flag before end of string");

  // the input side stalls only while the first packet register is full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (pkt_valid && !pkt_take))
    else $error("input stalled with free packet register");

endmodule

`default_nettype wire
